// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the pose integrator RTL.
// Needs a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every edge outside reset.
`define UPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define UPI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define UPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/upi_pkg.sv -----
// Shared types, constants and helper functions for the pose integrator.
// No dependencies; imported by the controller, datapath and top level.
package upi_pkg;

    localparam int MAX_ITERS = 24;
    localparam int STEP_W    = 5;

    // Angles in degrees, Q9.16
    localparam logic [24:0] FULL_TURN = 25'd23592960;
    localparam logic [24:0] HALF_TURN = 25'd11796480;
    localparam logic [24:0] QUARTER   = 25'd5898240;
    localparam logic [24:0] THREE_Q   = 25'd17694720;

    // CORDIC start value, gain-compensated, Q.30
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    // 128 full turns: lifts any heading sum to a non-negative value
    localparam logic [32:0] RED_OFFSET = 33'd3019898880;
    localparam logic [3:0]  RED_TOP    = 4'd8;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_STEP_TIME    = 2'd0;
    localparam logic [1:0] REG_INIT_X       = 2'd1;
    localparam logic [1:0] REG_INIT_Y       = 2'd2;
    localparam logic [1:0] REG_INIT_HEADING = 2'd3;

    // Multiply phase steps; each step before STEP_DRAIN issues one product
    localparam logic [2:0] STEP_LIN_COS = 3'd0;
    localparam logic [2:0] STEP_LIN_SIN = 3'd1;
    localparam logic [2:0] STEP_ANG_DT  = 3'd2;
    localparam logic [2:0] STEP_VX_DT   = 3'd3;
    localparam logic [2:0] STEP_VY_DT   = 3'd4;
    localparam logic [2:0] STEP_DRAIN   = 3'd5;

    typedef struct packed {
        logic              load;  // capture request, fold heading
        logic              rot;   // one CORDIC rotation
        logic              rnd;   // round cos/sin to Q1.16
        logic              mul;   // one multiply step
        logic              red;   // one heading reduction step
        logic              fin;   // commit heading, load output register
        logic [STEP_W-1:0] step;
    } upi_cmd_t;

    // atan(2^-i) in degrees, Q.24
    function automatic logic [31:0] atan_deg(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd754974720;
            5'd1:    v = 32'd445687602;
            5'd2:    v = 32'd235489088;
            5'd3:    v = 32'd119537938;
            5'd4:    v = 32'd60000934;
            5'd5:    v = 32'd30029717;
            5'd6:    v = 32'd15018523;
            5'd7:    v = 32'd7509720;
            5'd8:    v = 32'd3754917;
            5'd9:    v = 32'd1877466;
            5'd10:   v = 32'd938734;
            5'd11:   v = 32'd469367;
            5'd12:   v = 32'd234684;
            5'd13:   v = 32'd117342;
            5'd14:   v = 32'd58671;
            5'd15:   v = 32'd29335;
            5'd16:   v = 32'd14668;
            5'd17:   v = 32'd7334;
            5'd18:   v = 32'd3667;
            5'd19:   v = 32'd1833;
            5'd20:   v = 32'd917;
            5'd21:   v = 32'd458;
            5'd22:   v = 32'd229;
            5'd23:   v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/unicycle_pose_integrator_top.sv -----
// One request at a time: s_tready is high only while idle. Each request
//   passes the iterative CORDIC rotator, one rotation per cycle, then the
//   shared multiplier (six steps) and the nine-step heading reduction,
//   before the controller returns to idle.
// Reset (rst_n, async, active low): pose and elapsed time zero, step_time 655.
// Depends on upi_pkg, upi_ctrl and upi_datapath.
module unicycle_pose_integrator_top
    import upi_pkg::*;
#(
    parameter int CORDIC_ITERS = 16   // rotations per request, 8 to 24
) (
    input  logic         clk,
    input  logic         rst_n,
    // input requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // lin_vel[31:0], ang_vel[63:32]
    // result requests
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [207:0] m_tdata,   // pos_x[31:0], pos_y[63:32], heading[88:64],
                                    // vel_x[120:89], vel_y[152:121],
                                    // elapsed[200:153], zero fill above
    // configuration writes, only while idle
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,  // 0 step_time, 1 init_x, 2 init_y, 3 init_heading
    input  logic [31:0]  cfg_data
);

    upi_cmd_t cmd;

    // Controller: IDLE -> ROT (one CORDIC step per cycle) -> RND -> MUL
    // (pipelined shared multiplier) -> RED (heading mod 360) -> FIN.
    // FIN waits only for the output register to be free, so a new request
    // is taken while a finished result still waits downstream.
    upi_ctrl #(
        .ITERS (CORDIC_ITERS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // Datapath: holds pose state; writing init_x/y/heading reloads it.
    // Heading writes of 360 degrees or more have one full turn taken off on load.
    upi_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

// ----- rtl/upi_ctrl.sv -----
// Sequencer for the pose integrator: one-hot FSM and step counter.
// Depends on upi_pkg; drives upi_datapath through a upi_cmd_t.
`include "assert_macros.svh"

module upi_ctrl
    import upi_pkg::*;
#(
    parameter int ITERS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     m_tready,
    output logic     m_tvalid,
    output upi_cmd_t cmd
);

    localparam int ROT_N = (ITERS > MAX_ITERS) ? MAX_ITERS : ITERS;
    localparam logic [STEP_W-1:0] LAST_ROT = STEP_W'(ROT_N - 1);
    localparam logic [STEP_W-1:0] LAST_MUL = STEP_W'(STEP_DRAIN);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ROT  = 6'b000010,
        ST_RND  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_RED  = 6'b010000,
        ST_FIN  = 6'b100000
    } upi_state_t;

    upi_state_t        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                cmd.rot  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROT) begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                cmd.rnd    = 1'b1;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_MUL) begin
                    cnt_next   = STEP_W'(RED_TOP);
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.red  = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (slot_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.fin) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `UPI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `UPI_ASSERT_NEXT(a_fin_shows_result, cmd.fin, m_tvalid, "result lost after fin")
    `UPI_ASSERT_IMPL(a_fin_slot_free, cmd.fin, slot_free, "output overwritten")

endmodule

// ----- rtl/upi_datapath.sv -----
// Datapath: pose state, CORDIC rotator, shared multiplier, heading reduction.
// Depends on upi_pkg; sequenced by upi_ctrl through upi_cmd_t.
`include "assert_macros.svh"

module upi_datapath
    import upi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  upi_cmd_t     cmd,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_data,
    input  logic [63:0]  in_data,
    output logic [207:0] out_data
);

    // pose state
    logic [15:0]        step_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [24:0]        head_reg;
    logic [47:0]        time_reg;

    // per-request working registers
    logic signed [31:0] lin_reg, ang_reg;
    logic               neg_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] z_reg;
    logic signed [17:0] c_reg, s_reg;
    logic signed [49:0] prod_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic [32:0]        red_reg;
    logic [207:0]       out_reg;

    logic [24:0]        cfg_head;
    logic signed [25:0] fold;
    logic               fold_neg;
    logic signed [32:0] fold_w;
    logic signed [33:0] dx, dy;
    logic signed [32:0] atan_w;
    logic signed [33:0] xr, yr;
    logic signed [17:0] c_val, s_val;
    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [49:0] prod_w;
    logic signed [49:0] prod_rnd;
    logic signed [33:0] rnd_w;
    logic signed [33:0] x_sum, y_sum;
    logic signed [34:0] h_sum;
    logic [32:0]        red_cmp;

    assign cfg_head = (cfg_data[24:0] >= FULL_TURN) ? (cfg_data[24:0] - FULL_TURN)
                                                    : cfg_data[24:0];

    // fold heading into [-90, 90] degrees
    always_comb
    begin
        fold_neg = 1'b0;
        if (head_reg >= THREE_Q) begin
            fold = signed'({1'b0, head_reg}) - signed'({1'b0, FULL_TURN});
        end else if (head_reg > QUARTER) begin
            fold     = signed'({1'b0, head_reg}) - signed'({1'b0, HALF_TURN});
            fold_neg = 1'b1;
        end else begin
            fold = signed'({1'b0, head_reg});
        end
        fold_w = {{7{fold[25]}}, fold};
    end

    assign dx     = cy_reg >>> cmd.step;
    assign dy     = cx_reg >>> cmd.step;
    assign atan_w = signed'({1'b0, atan_deg(cmd.step)});

    // round Q.30 to Q1.16, clamp to [-1, 1], undo the half-turn fold
    always_comb
    begin
        xr = (cx_reg + 34'sd8192) >>> 14;
        yr = (cy_reg + 34'sd8192) >>> 14;
        if (xr > 34'sd65536) begin
            xr = 34'sd65536;
        end else if (xr < -34'sd65536) begin
            xr = -34'sd65536;
        end
        if (yr > 34'sd65536) begin
            yr = 34'sd65536;
        end else if (yr < -34'sd65536) begin
            yr = -34'sd65536;
        end
        c_val = neg_reg ? -xr[17:0] : xr[17:0];
        s_val = neg_reg ? -yr[17:0] : yr[17:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.step[2:0])
            STEP_LIN_COS:
            begin
                mul_a = lin_reg;
                mul_b = c_reg;
            end
            STEP_LIN_SIN:
            begin
                mul_a = lin_reg;
                mul_b = s_reg;
            end
            STEP_ANG_DT:
            begin
                mul_a = ang_reg;
                mul_b = signed'({2'b00, step_reg});
            end
            STEP_VX_DT:
            begin
                mul_a = vx_reg;
                mul_b = signed'({2'b00, step_reg});
            end
            STEP_VY_DT:
            begin
                mul_a = vy_reg;
                mul_b = signed'({2'b00, step_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_w   = mul_a * mul_b;
    assign prod_rnd = prod_reg + 50'sd32768;
    assign rnd_w    = prod_rnd[49:16];
    assign x_sum    = {{2{x_reg[31]}}, x_reg} + rnd_w;
    assign y_sum    = {{2{y_reg[31]}}, y_reg} + rnd_w;
    assign h_sum    = signed'({10'd0, head_reg}) + {rnd_w[33], rnd_w}
                    + signed'({2'b00, RED_OFFSET});
    assign red_cmp  = {8'd0, FULL_TURN} << cmd.step[3:0];

    // pose state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= 16'd655;
            x_reg    <= '0;
            y_reg    <= '0;
            head_reg <= '0;
            time_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_STEP_TIME:    step_reg <= cfg_data[15:0];
                REG_INIT_X:       x_reg    <= cfg_data;
                REG_INIT_Y:       y_reg    <= cfg_data;
                REG_INIT_HEADING: head_reg <= cfg_head;
                default:          ;
            endcase
        end else begin
            if (cmd.load) begin
                time_reg <= time_reg + {32'd0, step_reg};
            end
            // products land one step after they are issued
            if (cmd.mul && cmd.step[2:0] == STEP_VY_DT) begin
                x_reg <= sat32(x_sum);
            end
            if (cmd.mul && cmd.step[2:0] == STEP_DRAIN) begin
                y_reg <= sat32(y_sum);
            end
            if (cmd.fin) begin
                head_reg <= red_reg[24:0];
            end
        end
    end

    // working registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            lin_reg <= in_data[31:0];
            ang_reg <= in_data[63:32];
            neg_reg <= fold_neg;
            z_reg   <= fold_w <<< 8;
            cx_reg  <= GAIN_Q30;
            cy_reg  <= '0;
        end
        if (cmd.rot) begin
            if (!z_reg[32]) begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - atan_w;
            end else begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + atan_w;
            end
        end
        if (cmd.rnd) begin
            c_reg <= c_val;
            s_reg <= s_val;
        end
        if (cmd.mul) begin
            prod_reg <= prod_w;
            case (cmd.step[2:0])
                STEP_LIN_SIN: vx_reg  <= sat32(rnd_w);
                STEP_ANG_DT:  vy_reg  <= sat32(rnd_w);
                STEP_VX_DT:   red_reg <= h_sum[32:0];
                default:      ;
            endcase
        end
        if (cmd.red && red_reg >= red_cmp) begin
            red_reg <= red_reg - red_cmp;
        end
        if (cmd.fin) begin
            out_reg <= {7'd0, time_reg, vy_reg, vx_reg, red_reg[24:0], y_reg, x_reg};
        end
    end

    assign out_data = out_reg;

    `UPI_ASSERT(a_head_in_range, head_reg < FULL_TURN, "heading out of range")
    `UPI_ASSERT_IMPL(a_red_done, cmd.fin, red_reg < {8'd0, FULL_TURN}, "heading not reduced")

endmodule
